### sv/rtyc_pkg.sv
// Shared types and constants for the RGB to YCbCr palette entry unit.
package rtyc_pkg;

    // 17 magnitude bits plus sign hold every weighted sum of three 8-bit channels.
    localparam int SUM_W = 18;
    localparam int CH_W  = 8;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [CH_W-1:0]         chan_t;

    // Luma weights sum to 256; in each chroma row the positive weight equals
    // the sum of the two negative ones, so gray gives a zero chroma sum.
    localparam sum_t Y_R  = 18'sd77;
    localparam sum_t Y_G  = 18'sd150;
    localparam sum_t Y_B  = 18'sd29;
    localparam sum_t CB_R = 18'sd44;
    localparam sum_t CB_G = 18'sd87;
    localparam sum_t CB_B = 18'sd131;
    localparam sum_t CR_R = 18'sd131;
    localparam sum_t CR_G = 18'sd110;
    localparam sum_t CR_B = 18'sd21;

    localparam logic [7:0] ROUND_HALF = 8'd128;
    localparam logic [7:0] CHROMA_OFS = 8'd128;

endpackage

### sv/rgb_to_ycbcr_palette_entry_unit.sv
// Top level: three-stage RGB to packed YCbCr palette word pipeline.
//
//  Channel  Handshake            Payload
//  input    in_valid / in_stall  entry_index[7:0], red[7:0], green[7:0], blue[7:0]
//  output   out_valid/ out_stall write_index[7:0], palette_word[15:0]
//
// One item per clock while out_stall is low; out_valid is the stage 3 valid register.
// Stage 1 forms the three weighted sums, stage 2 divides, rounds and clamps,
// stage 3 requantizes and packs into the output register.
// rst_n clears all stage valid bits; payload registers are not reset.
// Each stage holds while the next one is full and stalled, so bubbles are squeezed out
// and a stalled output keeps its item unchanged.
module rgb_to_ycbcr_palette_entry_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  write_index,
    output logic [15:0] palette_word
);

    // Stage 1 registers
    logic             v1_reg;
    logic [7:0]       idx1_reg;
    rtyc_pkg::sum_t   ysum_reg, cbsum_reg, crsum_reg;
    rtyc_pkg::sum_t   ysum_next, cbsum_next, crsum_next;
    // Stage 2 registers
    logic             v2_reg;
    logic [7:0]       idx2_reg;
    rtyc_pkg::chan_t  y8_reg, cb8_reg, cr8_reg;
    rtyc_pkg::chan_t  y8_next, cb8_next, cr8_next;
    // Stage 3 (output) registers
    logic             v3_reg;
    logic [7:0]       idx3_reg;
    logic [15:0]      word_reg;
    logic [15:0]      word_next;

    logic             adv1, adv2, adv3;
    rtyc_pkg::sum_t   r_ext, g_ext, b_ext;
    logic [5:0]       y6;
    logic [3:0]       cb4, cr4;

    function automatic logic [5:0] quant_luma(input rtyc_pkg::chan_t v);
        logic [6:0] q;
        q = {1'b0, v[7:2]} + {6'd0, (v[1:0] == 2'd3)};
        return q[6] ? 6'h3F : q[5:0];
    endfunction

    function automatic logic [3:0] quant_chroma(input rtyc_pkg::chan_t v);
        logic [4:0] q;
        q = {1'b0, v[7:4]} + {4'd0, (v[3:0] > 4'd8)};
        return q[4] ? 4'hF : q[3:0];
    endfunction

    assign adv3     = !v3_reg || !out_stall;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    // Stage 1: constant-weight multiply-adds
    always_comb
    begin
        r_ext      = $signed({10'd0, red});
        g_ext      = $signed({10'd0, green});
        b_ext      = $signed({10'd0, blue});
        ysum_next  = r_ext * rtyc_pkg::Y_R + g_ext * rtyc_pkg::Y_G + b_ext * rtyc_pkg::Y_B;
        cbsum_next = b_ext * rtyc_pkg::CB_B - r_ext * rtyc_pkg::CB_R - g_ext * rtyc_pkg::CB_G;
        crsum_next = r_ext * rtyc_pkg::CR_R - g_ext * rtyc_pkg::CR_G - b_ext * rtyc_pkg::CR_B;
    end

    // Stage 2: divide, round, offset, clamp
    rtyc_div_clamp u_y_div
    (
        .sum       (ysum_reg),
        .is_chroma (1'b0),
        .value     (y8_next)
    );

    rtyc_div_clamp u_cb_div
    (
        .sum       (cbsum_reg),
        .is_chroma (1'b1),
        .value     (cb8_next)
    );

    rtyc_div_clamp u_cr_div
    (
        .sum       (crsum_reg),
        .is_chroma (1'b1),
        .value     (cr8_next)
    );

    // Stage 3: requantize and pack
    always_comb
    begin
        y6        = quant_luma(y8_reg);
        cb4       = quant_chroma(cb8_reg);
        cr4       = quant_chroma(cr8_reg);
        word_next = {y6, cb4, cr4, 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            idx1_reg  <= entry_index;
            ysum_reg  <= ysum_next;
            cbsum_reg <= cbsum_next;
            crsum_reg <= crsum_next;
        end
        if (adv2 && v1_reg)
        begin
            idx2_reg <= idx1_reg;
            y8_reg   <= y8_next;
            cb8_reg  <= cb8_next;
            cr8_reg  <= cr8_next;
        end
        if (adv3 && v2_reg)
        begin
            idx3_reg <= idx2_reg;
            word_reg <= word_next;
        end
    end

    assign out_valid    = v3_reg;
    assign write_index  = idx3_reg;
    assign palette_word = word_reg;

endmodule

### sv/rtyc_div_clamp.sv
// Sum / 256 with truncation toward zero, remainder rounding, chroma offset and 0..255 clamp.
module rtyc_div_clamp
(
    input  rtyc_pkg::sum_t  sum,
    input  logic            is_chroma,
    output rtyc_pkg::chan_t value
);

    logic [16:0]        mag;
    logic [9:0]         rnd_mag;
    logic signed [11:0] q;
    logic signed [11:0] ofs;
    logic signed [11:0] biased;

    always_comb
    begin
        if (sum[rtyc_pkg::SUM_W-1])
        begin
            mag = 17'(-sum);
        end
        else
        begin
            mag = sum[16:0];
        end
        // Truncated quotient magnitude; a remainder past one half pushes it away from zero,
        // which covers both the round-up and the round-down case.
        rnd_mag = {1'b0, mag[16:8]} + {9'd0, (mag[7:0] > rtyc_pkg::ROUND_HALF)};
        if (sum[rtyc_pkg::SUM_W-1])
        begin
            q = -$signed({2'b00, rnd_mag});
        end
        else
        begin
            q = $signed({2'b00, rnd_mag});
        end
        ofs    = is_chroma ? $signed({4'd0, rtyc_pkg::CHROMA_OFS}) : 12'sd0;
        biased = q + ofs;
        if (biased < 12'sd0)
        begin
            value = '0;
        end
        else if (biased > 12'sd255)
        begin
            value = '1;
        end
        else
        begin
            value = biased[7:0];
        end
    end

endmodule

### sim/testbench.sv
// Self-checking testbench for the RGB to YCbCr palette entry unit.
`timescale 1ns / 100ps

module testbench;

    // Conversion weights, magnitudes only; signs are applied in the sums below
    localparam int WY_R  = 77;
    localparam int WY_G  = 150;
    localparam int WY_B  = 29;
    localparam int WCB_R = 44;
    localparam int WCB_G = 87;
    localparam int WCB_B = 131;
    localparam int WCR_R = 131;
    localparam int WCR_G = 110;
    localparam int WCR_B = 21;

    localparam int RANDOM_PER_PHASE = 150;
    localparam int HOLD_CYCLES      = 60;
    localparam int DRAIN_CYCLES     = 8;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed
    {
        logic [7:0]  index;
        logic [15:0] word;
    } palette_entry_t;

    typedef struct packed
    {
        logic [7:0]  idx;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic        typed;
        logic [15:0] word;
    } color_row_t;

    localparam int N_DIRECTED = 18;

    // Rows with typed = 1 carry a hand-computed word; the rest use the predictor
    color_row_t color_rows [N_DIRECTED] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 16'h0220},  // black
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 16'hFE20},  // white, luma saturates
        '{8'd1,   8'd255, 8'd0,   8'd0,   1'b0, 16'h0000},  // red: Cr clamps high
        '{8'd2,   8'd0,   8'd255, 8'd0,   1'b0, 16'h0000},  // green
        '{8'd3,   8'd0,   8'd0,   8'd255, 1'b0, 16'h0000},  // blue: Cb clamps high
        '{8'd4,   8'd255, 8'd255, 8'd0,   1'b0, 16'h0000},  // yellow: Cb clamps low
        '{8'd5,   8'd0,   8'd255, 8'd255, 1'b0, 16'h0000},  // cyan: Cr clamps low
        '{8'd6,   8'd255, 8'd0,   8'd255, 1'b0, 16'h0000},  // magenta
        '{8'd7,   8'd128, 8'd128, 8'd128, 1'b0, 16'h0000},
        '{8'd8,   8'd1,   8'd1,   8'd1,   1'b0, 16'h0000},
        '{8'd9,   8'd254, 8'd254, 8'd254, 1'b0, 16'h0000},
        '{8'd10,  8'h55,  8'hAA,  8'h55,  1'b0, 16'h0000},
        '{8'd11,  8'hAA,  8'h55,  8'hAA,  1'b0, 16'h0000},
        '{8'd12,  8'd3,   8'd0,   8'd0,   1'b0, 16'h0000},
        '{8'd13,  8'd0,   8'd0,   8'd3,   1'b0, 16'h0000},
        '{8'd14,  8'd0,   8'd3,   8'd0,   1'b0, 16'h0000},
        '{8'd128, 8'd200, 8'd100, 8'd50,  1'b0, 16'h0000},
        '{8'd127, 8'd10,  8'd240, 8'd30,  1'b0, 16'h0000}
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  entry_index = 8'd0;
    logic [7:0]  red         = 8'd0;
    logic [7:0]  green       = 8'd0;
    logic [7:0]  blue        = 8'd0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  write_index;
    logic [15:0] palette_word;

    palette_entry_t pending_words [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int items_sent    = 0;
    int words_checked = 0;
    int error_count   = 0;
    int backpressure_cycles = 0;

    rgb_to_ycbcr_palette_entry_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .entry_index  (entry_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .write_index  (write_index),
        .palette_word (palette_word)
    );

    always #10 clk = ~clk;

    // ---------------- predictor ----------------

    // Divide by 256 truncating toward zero, then round on the remainder
    function automatic int scale_down(input int sum, input bit allow_down);
        int q;
        int rem;
        q   = sum / 256;
        rem = sum % 256;
        if (rem > 128)
            q = q + 1;
        else if (allow_down && rem < -128)
            q = q - 1;
        return q;
    endfunction

    function automatic int clip8(input int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    function automatic int requantize(input int v, input int step, input int limit,
                                      input int top);
        int q;
        q = v / step;
        if ((v % step) > limit)
            q = q + 1;
        if (q > top)
            q = top;
        return q;
    endfunction

    function automatic logic [15:0] ycbcr_word(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        int ri;
        int gi;
        int bi;
        int luma;
        int cb;
        int cr;
        logic [5:0] y6;
        logic [3:0] cb4;
        logic [3:0] cr4;
        ri = int'(r);
        gi = int'(g);
        bi = int'(b);
        luma = scale_down(ri * WY_R + gi * WY_G + bi * WY_B, 1'b0);
        cb   = scale_down(-(ri * WCB_R) - gi * WCB_G + bi * WCB_B, 1'b1) + 128;
        cr   = scale_down(ri * WCR_R - gi * WCR_G - bi * WCR_B, 1'b1) + 128;
        y6   = 6'(requantize(clip8(luma), 4, 2, 63));
        cb4  = 4'(requantize(clip8(cb), 16, 8, 15));
        cr4  = 4'(requantize(clip8(cr), 16, 8, 15));
        return {y6, cb4, cr4, 2'b00};
    endfunction

    // ---------------- input side ----------------

    task automatic offer_item(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic typed,
                              input logic [15:0] typed_word);
        int gap;
        palette_entry_t entry;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        entry_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        entry.index = idx;
        entry.word  = typed ? typed_word : ycbcr_word(r, g, b);
        pending_words.push_back(entry);
        items_sent++;
    endtask

    // Channel value biased toward the ends of the range
    function automatic logic [7:0] pick_channel();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic random_items(input int count);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        for (int i = 0; i < count; i++)
        begin
            r = pick_channel();
            g = pick_channel();
            b = pick_channel();
            offer_item(8'($urandom_range(255)), r, g, b, 1'b0, 16'h0000);
        end
    endtask

    // ---------------- output side ----------------

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (rst_n && in_valid && in_stall)
            backpressure_cycles++;
    end

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        palette_entry_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
                flag_error($sformatf("unexpected item index %0d word %h",
                                     write_index, palette_word));
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (write_index !== want.index || palette_word !== want.word)
                    flag_error($sformatf("index exp %0d got %0d, word exp %h got %h",
                                         want.index, write_index, want.word,
                                         palette_word));
            end
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 64;
        for (int i = 0; i < N_DIRECTED; i++)
            offer_item(color_rows[i].idx, color_rows[i].r, color_rows[i].g,
                       color_rows[i].b, color_rows[i].typed, color_rows[i].word);
        random_items(RANDOM_PER_PHASE);

        send_idle_pct = 64;
        recv_idle_pct = 27;
        random_items(RANDOM_PER_PHASE);

        // Back-to-back input against a long output hold fills the pipeline
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        random_items(RANDOM_PER_PHASE);
        in_valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items (%0d directed), checked %0d palette words, %0d errors.",
                 items_sent, N_DIRECTED, words_checked, error_count);
        $display("Three idle mixes plus a %0d-cycle output hold; input stalled %0d cycles.",
                 HOLD_CYCLES, backpressure_cycles);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### files.f
sv/rtyc_pkg.sv
sv/rtyc_div_clamp.sv
sv/rgb_to_ycbcr_palette_entry_unit.sv
sim/testbench.sv
